[design/twrs_pkg.sv]
package twrs_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int GAIN_WIDTH   = 16;
    localparam int GAIN_FRAC    = 8;
    localparam int MODE_WIDTH   = 4;
    localparam int NUM_AXES     = 6;
    localparam int AXIS_IDX_W   = $clog2(NUM_AXES);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LINEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANGULAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2     = 3'd5;

    // mode flag bit positions
    localparam int MODE_ROT_EN   = 0;
    localparam int MODE_DOM_EN   = 1;
    localparam int MODE_OUT_EN   = 2;
    localparam int MODE_GUARD_EN = 3;

    localparam logic [MODE_WIDTH-1:0] MODE_RESET = 4'd4;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd256;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [NUM_AXES-1:0][SAMPLE_WIDTH-1:0] t_vec;

    typedef struct packed {
        t_sample lin_x;
        t_sample lin_y;
        t_sample lin_z;
        t_sample ang_x;
        t_sample ang_y;
        t_sample ang_z;
    } t_twist_in;

    typedef struct packed {
        t_sample    out_lin_x;
        t_sample    out_lin_y;
        t_sample    out_lin_z;
        t_sample    out_ang_x;
        t_sample    out_ang_y;
        t_sample    out_ang_z;
        logic       collision_guard;
    } t_twist_out;

    typedef struct packed {
        logic dom_en;
        logic out_en;
        logic guard;
    } t_merge_ctrl;

endpackage

[design/twrs_lane.sv]
module twrs_lane #(
    parameter int COEF_WIDTH = twrs_pkg::COEF_WIDTH,
    parameter int COL        = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic                                  i_rot_en,
    input  logic [3*twrs_pkg::SAMPLE_WIDTH-1:0]   i_triple,
    input  logic [3*COEF_WIDTH-1:0]               i_row,
    input  logic signed [twrs_pkg::GAIN_WIDTH-1:0] i_gain,
    output logic signed [twrs_pkg::SAMPLE_WIDTH-1:0] o_sample
);
    localparam int SW    = twrs_pkg::SAMPLE_WIDTH;
    localparam int GW    = twrs_pkg::GAIN_WIDTH;
    localparam int GF    = twrs_pkg::GAIN_FRAC;
    localparam int CF    = COEF_WIDTH - 2;
    localparam int PW    = COEF_WIDTH + SW;
    localparam int SUM_W = PW + 2;
    localparam int GP_W  = SW + GW;

    logic signed [PW-1:0]    r_prod [3];
    logic signed [SW-1:0]    r_own;
    logic signed [SW-1:0]    r_rot;
    logic signed [GP_W-1:0]  r_gp;
    logic signed [SW-1:0]    r_out;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SW-1:0]    w_rot;
    logic signed [SW-1:0]    w_scaled;
    logic [SUM_W-CF-SW:0]    w_rot_hi;
    logic [GP_W-GF-SW:0]     w_gp_hi;

    // stage 1: coefficient times sample, one product per column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed(i_row[k*COEF_WIDTH +: COEF_WIDTH])
                           * $signed(i_triple[k*SW +: SW]);
            end
            r_own <= $signed(i_triple[COL*SW +: SW]);
        end
    end

    // stage 2: row sum, floor shift and saturation, or bypass
    assign w_sum    = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
    assign w_rot_hi = w_sum[SUM_W-1:CF+SW-1];
    assign w_rot    = ((&w_rot_hi) || !(|w_rot_hi)) ? w_sum[CF+SW-1:CF]
                    : {w_sum[SUM_W-1], {(SW-1){~w_sum[SUM_W-1]}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= i_rot_en ? w_rot : r_own;
        end
    end

    // stage 3: gain product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gp <= r_rot * i_gain;
        end
    end

    // stage 4: floor shift and saturation of the scaled sample
    assign w_gp_hi  = r_gp[GP_W-1:GF+SW-1];
    assign w_scaled = ((&w_gp_hi) || !(|w_gp_hi)) ? r_gp[GF+SW-1:GF]
                    : {r_gp[GP_W-1], {(SW-1){~r_gp[GP_W-1]}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= w_scaled;
        end
    end

    assign o_sample = r_out;

endmodule

[design/twrs_merge.sv]
module twrs_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  twrs_pkg::t_vec         i_vec,
    input  twrs_pkg::t_merge_ctrl  i_ctrl,
    output logic                   o_vld,
    output logic                   o_m1_vld,
    output twrs_pkg::t_twist_out   o_data
);
    localparam int SW = twrs_pkg::SAMPLE_WIDTH;
    localparam int NA = twrs_pkg::NUM_AXES;
    localparam int IW = twrs_pkg::AXIS_IDX_W;

    logic                   r_m1_vld;
    twrs_pkg::t_vec         r_vec;
    logic                   r_dup;
    logic signed [SW-1:0]   r_mn;
    logic signed [SW-1:0]   r_mx;
    logic [IW-1:0]          r_imn;
    logic [IW-1:0]          r_imx;
    logic                   r_out_vld;
    twrs_pkg::t_twist_out   r_out;

    logic                   w_dup;
    logic signed [SW-1:0]   w_mn;
    logic signed [SW-1:0]   w_mx;
    logic [IW-1:0]          w_imn;
    logic [IW-1:0]          w_imx;
    logic signed [SW:0]     w_ext_sum;
    logic                   w_pick_max;
    twrs_pkg::t_vec         w_sel;
    logic                   w_any;

    // duplicate search and first-index min / max over the six lanes
    always_comb begin
        w_dup = 1'b0;
        for (int i = 0; i < NA; i++) begin
            for (int j = i + 1; j < NA; j++) begin
                if ((i_vec[i] != '0) && (i_vec[i] == i_vec[j])) begin
                    w_dup = 1'b1;
                end
            end
        end
        w_mn  = $signed(i_vec[0]);
        w_mx  = $signed(i_vec[0]);
        w_imn = '0;
        w_imx = '0;
        for (int i = 1; i < NA; i++) begin
            if ($signed(i_vec[i]) < w_mn) begin
                w_mn  = $signed(i_vec[i]);
                w_imn = IW'(i);
            end
            if ($signed(i_vec[i]) > w_mx) begin
                w_mx  = $signed(i_vec[i]);
                w_imx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (i_en) begin
            r_m1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= i_vec;
            r_dup <= w_dup;
            r_mn  <= w_mn;
            r_mx  <= w_mx;
            r_imn <= w_imn;
            r_imx <= w_imx;
        end
    end

    // dominant axis selection
    assign w_ext_sum  = (SW+1)'(r_mn) + (SW+1)'(r_mx);
    assign w_pick_max = !w_ext_sum[SW] && (w_ext_sum != '0);

    always_comb begin
        w_sel = '0;
        if (!i_ctrl.dom_en) begin
            w_sel = r_vec;
        end else if (!r_dup) begin
            if (w_pick_max) begin
                w_sel[r_imx] = r_mx;
            end else begin
                w_sel[r_imn] = r_mn;
            end
        end
    end

    assign w_any = |w_sel;

    // output register, marked valid only for results that are emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_m1_vld && i_ctrl.out_en && w_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_lin_x       <= w_sel[0];
            r_out.out_lin_y       <= w_sel[1];
            r_out.out_lin_z       <= w_sel[2];
            r_out.out_ang_x       <= w_sel[3];
            r_out.out_ang_y       <= w_sel[4];
            r_out.out_ang_z       <= w_sel[5];
            r_out.collision_guard <= i_ctrl.guard;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_m1_vld = r_m1_vld;
    assign o_data   = r_out;

endmodule

[design/twist_rotate_scale_dominant_axis_top.sv]
// Six-axis velocity command conditioner.
// Input channel: i_in_valid / o_in_stall carry one twist (six signed Q4.12
// samples) per transfer. Output channel: o_out_valid / i_out_stall carry the
// conditioned twist and the collision guard flag.
// Each twist is optionally rotated by the 3x3 matrix, scaled by the linear
// or angular gain, reduced to its dominant axis when that mode is on, and
// dropped when output is disabled or every component comes out zero.
// Throughput: one twist per cycle while the output is not held, set by six
// parallel lanes of four register stages each (products, rotation sum,
// gain product, gain shift) followed by two merge stages.
// When the output is stalled while holding a result, the whole pipeline
// holds and o_in_stall rises; otherwise input is taken every cycle.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data. The
// user makes writes only while no twist is in flight; it is not enforced.
// Reset (synchronous, active low) empties the pipeline and loads the
// identity matrix, unity gains and mode flags with only output enabled.
module twist_rotate_scale_dominant_axis_top #(
    parameter int COEF_WIDTH = twrs_pkg::COEF_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  twrs_pkg::t_twist_in                    i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output twrs_pkg::t_twist_out                   o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [twrs_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((3*COEF_WIDTH > twrs_pkg::GAIN_WIDTH) ? 3*COEF_WIDTH
                   : twrs_pkg::GAIN_WIDTH)-1:0]    i_cfg_data
);
    localparam int SW    = twrs_pkg::SAMPLE_WIDTH;
    localparam int GW    = twrs_pkg::GAIN_WIDTH;
    localparam int NA    = twrs_pkg::NUM_AXES;
    localparam int ROW_W = 3 * COEF_WIDTH;
    localparam int NSTG  = 4;

    logic [twrs_pkg::MODE_WIDTH-1:0] r_mode;
    logic signed [GW-1:0]            r_gain_lin;
    logic signed [GW-1:0]            r_gain_ang;
    logic [ROW_W-1:0]                r_row [3];
    logic [NSTG-1:0]                 r_vld;

    logic                            w_adv;
    logic [3*SW-1:0]                 w_lin;
    logic [3*SW-1:0]                 w_ang;
    twrs_pkg::t_vec                  w_lane_out;
    twrs_pkg::t_merge_ctrl           w_ctrl;
    logic                            w_m1_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= twrs_pkg::MODE_RESET;
            r_gain_lin <= twrs_pkg::GAIN_RESET;
            r_gain_ang <= twrs_pkg::GAIN_RESET;
            for (int k = 0; k < 3; k++) begin
                r_row[k] <= {{(ROW_W-1){1'b0}}, 1'b1} << (COEF_WIDTH - 2 + k*COEF_WIDTH);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                twrs_pkg::CFG_MODE_FLAGS:   r_mode     <= i_cfg_data[twrs_pkg::MODE_WIDTH-1:0];
                twrs_pkg::CFG_GAIN_LINEAR:  r_gain_lin <= i_cfg_data[GW-1:0];
                twrs_pkg::CFG_GAIN_ANGULAR: r_gain_ang <= i_cfg_data[GW-1:0];
                twrs_pkg::CFG_ROT_ROW0:     r_row[0]   <= i_cfg_data[ROW_W-1:0];
                twrs_pkg::CFG_ROT_ROW1:     r_row[1]   <= i_cfg_data[ROW_W-1:0];
                twrs_pkg::CFG_ROT_ROW2:     r_row[2]   <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline advances unless a finished result is held by the receiver
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // lane inputs, x in the low bits
    assign w_lin = {i_in_data.lin_z, i_in_data.lin_y, i_in_data.lin_x};
    assign w_ang = {i_in_data.ang_z, i_in_data.ang_y, i_in_data.ang_x};

    // six lanes: lane g takes row g mod 3 over its own triple
    for (genvar g = 0; g < NA; g++) begin : g_lane
        twrs_lane #(
            .COEF_WIDTH (COEF_WIDTH),
            .COL        (g % 3)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_rot_en (r_mode[twrs_pkg::MODE_ROT_EN]),
            .i_triple ((g < 3) ? w_lin : w_ang),
            .i_row    (r_row[g % 3]),
            .i_gain   ((g < 3) ? r_gain_lin : r_gain_ang),
            .o_sample (w_lane_out[g])
        );
    end

    // merge of the lanes: dominant axis and emit decision
    assign w_ctrl.dom_en = r_mode[twrs_pkg::MODE_DOM_EN];
    assign w_ctrl.out_en = r_mode[twrs_pkg::MODE_OUT_EN];
    assign w_ctrl.guard  = r_mode[twrs_pkg::MODE_GUARD_EN];

    twrs_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_vld    (r_vld[NSTG-1]),
        .i_vec    (w_lane_out),
        .i_ctrl   (w_ctrl),
        .o_vld    (o_out_valid),
        .o_m1_vld (w_m1_vld),
        .o_data   (o_out_data)
    );

    // an emitted result never has all components zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_lin_x != '0 || o_out_data.out_lin_y != '0 ||
                         o_out_data.out_lin_z != '0 || o_out_data.out_ang_x != '0 ||
                         o_out_data.out_ang_y != '0 || o_out_data.out_ang_z != '0))
        else $error("result with all components zero");

    // no result appears out of an empty pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0 && !w_m1_vld && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared with no twist in flight");

    // a held result keeps the lanes frozen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

endmodule

[dv/tb_twist_rotate_scale_dominant_axis_top.sv]
`timescale 1ns / 100ps

module tb_twist_rotate_scale_dominant_axis_top;

    import twrs_pkg::*;

    localparam int CFG_DATA_W   = (3 * COEF_WIDTH > GAIN_WIDTH) ? 3 * COEF_WIDTH : GAIN_WIDTH;
    localparam int COEF_FRAC    = COEF_WIDTH - 2;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_SETS  = 7;
    localparam int SET_ITEMS    = 250;

    // register slots the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    // mode flag words
    localparam logic [MODE_WIDTH-1:0] M_ROT   = MODE_WIDTH'(1 << MODE_ROT_EN);
    localparam logic [MODE_WIDTH-1:0] M_DOM   = MODE_WIDTH'(1 << MODE_DOM_EN);
    localparam logic [MODE_WIDTH-1:0] M_OUT   = MODE_WIDTH'(1 << MODE_OUT_EN);
    localparam logic [MODE_WIDTH-1:0] M_GUARD = MODE_WIDTH'(1 << MODE_GUARD_EN);

    localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = GAIN_RESET;
    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX   = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
    localparam logic [GAIN_WIDTH-1:0] GAIN_MIN   = {1'b1, {(GAIN_WIDTH-1){1'b0}}};
    localparam logic [COEF_WIDTH-1:0] COEF_ONE   = COEF_WIDTH'(1 << COEF_FRAC);
    localparam logic [COEF_WIDTH-1:0] COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_twist_in             i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_twist_out            o_out_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // mirror of the block's configuration
    logic [MODE_WIDTH-1:0]        cur_mode;
    logic signed [GAIN_WIDTH-1:0] cur_gain_lin;
    logic signed [GAIN_WIDTH-1:0] cur_gain_ang;
    logic [3*COEF_WIDTH-1:0]      cur_rows [3];

    t_twist_out expected_twists [$];
    string      axis_names [6] = '{"out_lin_x", "out_lin_y", "out_lin_z",
                                   "out_ang_x", "out_ang_y", "out_ang_z"};
    int         n_sent      = 0;
    int         n_checked   = 0;
    int         n_errors    = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_left   = 0;

    twist_rotate_scale_dominant_axis_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_twist_rotate_scale_dominant_axis_top: errors");
            $finish;
        end
    end

    // receiver stall: long hold-off first, else random idling
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_twist_out want;
        t_sample    want_ax [6];
        t_sample    got_ax [6];
        int         k;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_twists.size() == 0) begin
                $error("result transfer with no prediction pending");
                n_errors++;
            end else begin
                want    = expected_twists.pop_front();
                want_ax = '{want.out_lin_x, want.out_lin_y, want.out_lin_z,
                            want.out_ang_x, want.out_ang_y, want.out_ang_z};
                got_ax  = '{o_out_data.out_lin_x, o_out_data.out_lin_y, o_out_data.out_lin_z,
                            o_out_data.out_ang_x, o_out_data.out_ang_y, o_out_data.out_ang_z};
                for (k = 0; k < 6; k++) begin
                    if (got_ax[k] !== want_ax[k]) begin
                        $error("%s expected %0d got %0d", axis_names[k], want_ax[k], got_ax[k]);
                        n_errors++;
                    end
                end
                if (o_out_data.collision_guard !== want.collision_guard) begin
                    $error("collision_guard expected %0d got %0d",
                           want.collision_guard, o_out_data.collision_guard);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    function automatic longint clamp_sample(input longint v);
        if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
        if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
        return v;
    endfunction

    // rotate, scale and reduce one twist; returns 1 when a result comes out
    function automatic bit condition_twist(input t_twist_in tw, output t_twist_out res);
        longint v [6];
        longint r [6];
        longint acc, g, mn, mx;
        logic signed [COEF_WIDTH-1:0] c;
        int     i, j, t, imn, imx;
        bit     dup, any;
        res  = '0;
        v[0] = tw.lin_x;
        v[1] = tw.lin_y;
        v[2] = tw.lin_z;
        v[3] = tw.ang_x;
        v[4] = tw.ang_y;
        v[5] = tw.ang_z;
        // matrix applied to each triple, floor shift then saturate
        if (cur_mode[MODE_ROT_EN]) begin
            for (t = 0; t < 2; t++) begin
                for (i = 0; i < 3; i++) begin
                    acc = 0;
                    for (j = 0; j < 3; j++) begin
                        c   = cur_rows[i][j*COEF_WIDTH +: COEF_WIDTH];
                        acc += longint'(c) * v[t*3 + j];
                    end
                    r[t*3 + i] = clamp_sample(acc >>> COEF_FRAC);
                end
            end
            v = r;
        end
        // per-triple gain
        for (i = 0; i < 6; i++) begin
            g    = (i < 3) ? longint'(cur_gain_lin) : longint'(cur_gain_ang);
            v[i] = clamp_sample((v[i] * g) >>> GAIN_FRAC);
        end
        // dominant axis: equal nonzero pair clears all, else keep one extreme
        if (cur_mode[MODE_DOM_EN]) begin
            dup = 1'b0;
            for (i = 0; i < 6; i++)
                for (j = i + 1; j < 6; j++)
                    if (v[i] != 0 && v[i] == v[j])
                        dup = 1'b1;
            mn  = v[0];
            mx  = v[0];
            imn = 0;
            imx = 0;
            for (i = 1; i < 6; i++) begin
                if (v[i] < mn) begin
                    mn  = v[i];
                    imn = i;
                end
                if (v[i] > mx) begin
                    mx  = v[i];
                    imx = i;
                end
            end
            for (i = 0; i < 6; i++)
                v[i] = 0;
            if (!dup) begin
                if (mx + mn > 0) v[imx] = mx;
                else             v[imn] = mn;
            end
        end
        any = 1'b0;
        for (i = 0; i < 6; i++)
            if (v[i] != 0) any = 1'b1;
        if (!cur_mode[MODE_OUT_EN] || !any) return 1'b0;
        res.out_lin_x       = v[0][SAMPLE_WIDTH-1:0];
        res.out_lin_y       = v[1][SAMPLE_WIDTH-1:0];
        res.out_lin_z       = v[2][SAMPLE_WIDTH-1:0];
        res.out_ang_x       = v[3][SAMPLE_WIDTH-1:0];
        res.out_ang_y       = v[4][SAMPLE_WIDTH-1:0];
        res.out_ang_z       = v[5][SAMPLE_WIDTH-1:0];
        res.collision_guard = cur_mode[MODE_GUARD_EN];
        return 1'b1;
    endfunction

    function automatic t_twist_in make_twist(input int a, input int b, input int c,
                                             input int d, input int e, input int f);
        t_twist_in tw;
        tw.lin_x = SAMPLE_WIDTH'(a);
        tw.lin_y = SAMPLE_WIDTH'(b);
        tw.lin_z = SAMPLE_WIDTH'(c);
        tw.ang_x = SAMPLE_WIDTH'(d);
        tw.ang_y = SAMPLE_WIDTH'(e);
        tw.ang_z = SAMPLE_WIDTH'(f);
        return tw;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_row(input logic [COEF_WIDTH-1:0] c0,
                                                       input logic [COEF_WIDTH-1:0] c1,
                                                       input logic [COEF_WIDTH-1:0] c2);
        return CFG_DATA_W'({c2, c1, c0});
    endfunction

    // mix of full-range, small, zero and extreme samples with repeats
    function automatic t_twist_in random_twist();
        t_sample s [6];
        int      k;
        for (k = 0; k < 6; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: s[k] = SAMPLE_WIDTH'($urandom);
                5:             s[k] = SAMPLE_WIDTH'(int'($urandom_range(0, 128)) - 64);
                6:             s[k] = '0;
                7:             s[k] = SAMPLE_MAX;
                8:             s[k] = SAMPLE_MIN;
                default:       s[k] = SAMPLE_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            s[$urandom_range(0, 5)] = s[$urandom_range(0, 5)];
        if ($urandom_range(0, 19) == 0)
            for (k = 0; k < 6; k++) s[k] = '0;
        return make_twist(s[0], s[1], s[2], s[3], s[4], s[5]);
    endfunction

    function automatic logic [GAIN_WIDTH-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_UNITY;
            1:       return GAIN_MAX;
            2:       return GAIN_MIN;
            3:       return GAIN_WIDTH'(int'($urandom_range(0, 1024)) - 512);
            default: return GAIN_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_row(input int row);
        logic [COEF_WIDTH-1:0] c [3];
        int                    k;
        case ($urandom_range(0, 4))
            0: begin
                for (k = 0; k < 3; k++) c[k] = (k == row) ? COEF_ONE : '0;
            end
            1: return CFG_DATA_W'({$urandom, $urandom});
            2: begin
                for (k = 0; k < 3; k++) c[k] = '0;
                c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
            end
            3: begin
                for (k = 0; k < 3; k++) c[k] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end
            default: begin
                for (k = 0; k < 3; k++)
                    c[k] = COEF_WIDTH'(int'($urandom_range(0, 4096)) - 2048);
            end
        endcase
        return pack_row(c[0], c[1], c[2]);
    endfunction

    function automatic void load_reset_config();
        int k;
        cur_mode     = MODE_RESET;
        cur_gain_lin = GAIN_RESET;
        cur_gain_ang = GAIN_RESET;
        for (k = 0; k < 3; k++)
            cur_rows[k] = (3*COEF_WIDTH)'(COEF_ONE) << (k * COEF_WIDTH);
    endfunction

    // one register write, mirrored into the predictor
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE_FLAGS:   cur_mode     = data[MODE_WIDTH-1:0];
            CFG_GAIN_LINEAR:  cur_gain_lin = data[GAIN_WIDTH-1:0];
            CFG_GAIN_ANGULAR: cur_gain_ang = data[GAIN_WIDTH-1:0];
            CFG_ROT_ROW0:     cur_rows[0]  = data[3*COEF_WIDTH-1:0];
            CFG_ROT_ROW1:     cur_rows[1]  = data[3*COEF_WIDTH-1:0];
            CFG_ROT_ROW2:     cur_rows[2]  = data[3*COEF_WIDTH-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every predicted result is out and the pipe has emptied
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_twists.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [MODE_WIDTH-1:0] mode,
                                input logic [GAIN_WIDTH-1:0] gain_lin,
                                input logic [GAIN_WIDTH-1:0] gain_ang,
                                input logic [CFG_DATA_W-1:0] row0,
                                input logic [CFG_DATA_W-1:0] row1,
                                input logic [CFG_DATA_W-1:0] row2);
        settle_block();
        cfg_write(CFG_MODE_FLAGS, CFG_DATA_W'(mode));
        cfg_write(CFG_GAIN_LINEAR, CFG_DATA_W'(gain_lin));
        cfg_write(CFG_GAIN_ANGULAR, CFG_DATA_W'(gain_ang));
        cfg_write(CFG_ROT_ROW0, row0);
        cfg_write(CFG_ROT_ROW1, row1);
        cfg_write(CFG_ROT_ROW2, row2);
    endtask

    // one input transfer, with an optional gap ahead of it
    task automatic send_twist(input t_twist_in tw);
        t_twist_out want;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tw;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (condition_twist(tw, want))
            expected_twists.push_back(want);
    endtask

    // reset values: identity, unity gains, output only
    task automatic test_reset_defaults();
        send_twist(make_twist(32767, 32767, 32767, 32767, 32767, 32767));
        send_twist(make_twist(-32768, -32768, -32768, -32768, -32768, -32768));
        send_twist(make_twist(0, 0, 0, 0, 0, 0));
        send_twist(make_twist(1, -1, 'h1234, -'h1234, 'h0F0F, -'h7001));
    endtask

    // unimplemented indexes ignored, bits above each register dropped
    task automatic test_register_writes();
        settle_block();
        cfg_write(CFG_IDX_SPARE_A, '1);
        cfg_write(CFG_IDX_SPARE_B, '1);
        cfg_write(CFG_MODE_FLAGS, {{(CFG_DATA_W-MODE_WIDTH){1'b1}}, M_OUT | M_GUARD});
        cfg_write(CFG_GAIN_LINEAR, {32'hFFFF_A5A5, 16'h0080});
        cfg_write(CFG_GAIN_ANGULAR, {32'h1234_5678, 16'hFF00});
        cfg_write(CFG_ROT_ROW0, pack_row(COEF_ONE, '0, '0));
        cfg_write(CFG_ROT_ROW1, pack_row('0, COEF_ONE, '0));
        cfg_write(CFG_ROT_ROW2, pack_row('0, '0, COEF_ONE));
        send_twist(make_twist('h1000, -'h1000, 3, -3, 32767, -32768));
        send_twist(make_twist(-1, 1, 0, 1, -1, 0));
    endtask

    // rotation with permutation, saturation and floor rounding, then gain extremes
    task automatic test_rotation_and_gain();
        apply_config(M_ROT | M_OUT, GAIN_UNITY, GAIN_UNITY,
                     pack_row('0, -COEF_ONE, '0), pack_row('0, '0, COEF_ONE),
                     pack_row(COEF_ONE, '0, '0));
        send_twist(make_twist(100, -200, 300, -400, 500, -600));
        send_twist(make_twist(-32768, 32767, 1, 0, -32768, 7));
        apply_config(M_ROT | M_OUT, GAIN_UNITY, GAIN_UNITY,
                     pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                     pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                     pack_row(COEF_MIN, COEF_MAX, COEF_MIN));
        send_twist(make_twist(-32768, -32768, -32768, 32767, 32767, 32767));
        send_twist(make_twist(32767, -32768, 32767, -32768, 32767, -32768));
        apply_config(M_ROT | M_OUT, GAIN_UNITY, GAIN_UNITY,
                     pack_row(COEF_WIDTH'(1), '0, '0), pack_row('0, COEF_WIDTH'(1), '0),
                     pack_row(COEF_WIDTH'(3), COEF_WIDTH'(1), '0));
        send_twist(make_twist(-1, 1, -5, -32768, 32767, -3));
        apply_config(M_OUT, GAIN_MAX, GAIN_MIN, pack_row(COEF_ONE, '0, '0),
                     pack_row('0, COEF_ONE, '0), pack_row('0, '0, COEF_ONE));
        send_twist(make_twist(1000, -1000, 1, -1000, 1000, -1));
        apply_config(M_OUT, GAIN_WIDTH'(1), GAIN_WIDTH'(-3), pack_row(COEF_ONE, '0, '0),
                     pack_row('0, COEF_ONE, '0), pack_row('0, '0, COEF_ONE));
        send_twist(make_twist(-1, 255, 256, -257, 85, -86));
    endtask

    // dominant axis: duplicates, max pick, min pick, balanced pick, all zero
    task automatic test_dominant_axis();
        apply_config(M_DOM | M_OUT, GAIN_UNITY, GAIN_UNITY, pack_row(COEF_ONE, '0, '0),
                     pack_row('0, COEF_ONE, '0), pack_row('0, '0, COEF_ONE));
        send_twist(make_twist(100, 5, 100, 0, 0, 0));
        send_twist(make_twist(0, 0, 0, 0, 0, 7));
        send_twist(make_twist(10, -3, 20, 0, 5, -8));
        send_twist(make_twist(10, -30, 20, 0, 5, -8));
        send_twist(make_twist(5, -5, 1, 2, 3, 4));
        send_twist(make_twist(0, 0, 0, 0, 0, 0));
    endtask

    // output disabled drops everything; guard flag follows mode
    task automatic test_output_gating();
        apply_config(M_GUARD | M_DOM, GAIN_UNITY, GAIN_UNITY, pack_row(COEF_ONE, '0, '0),
                     pack_row('0, COEF_ONE, '0), pack_row('0, '0, COEF_ONE));
        send_twist(make_twist(1, 2, 3, 4, 5, 6));
        send_twist(make_twist(-32768, 32767, -1, 1, 0, 9));
        apply_config(M_ROT | M_DOM | M_OUT | M_GUARD, GAIN_UNITY, GAIN_UNITY,
                     pack_row(COEF_ONE, '0, '0), pack_row('0, COEF_ONE, '0),
                     pack_row('0, '0, COEF_ONE));
        send_twist(make_twist(-7, 2, 3, 4, 5, 6));
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_hold();
        apply_config(M_OUT, GAIN_UNITY, GAIN_UNITY, pack_row(COEF_ONE, '0, '0),
                     pack_row('0, COEF_ONE, '0), pack_row('0, '0, COEF_ONE));
        hold_left = HOLD_CYCLES;
        repeat (40) send_twist(random_twist());
    endtask

    // random settings with random traffic, idling profile changes over the run
    task automatic test_random_traffic();
        int                    set_no;
        logic [MODE_WIDTH-1:0] mode;
        for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            mode = MODE_WIDTH'($urandom);
            if ($urandom_range(0, 4) != 0) mode = mode | M_OUT;
            apply_config(mode, pick_gain(), pick_gain(), pick_row(0), pick_row(1), pick_row(2));
            if (set_no < 2) begin
                tx_idle_pct = 30;
                rx_idle_pct = 79;
            end else if (set_no < 4) begin
                tx_idle_pct = 79;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            repeat (SET_ITEMS) send_twist(random_twist());
        end
    endtask

    initial begin
        load_reset_config();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_writes();
        test_rotation_and_gain();
        test_dominant_axis();
        test_output_gating();
        test_output_hold();
        test_random_traffic();
        settle_block();

        $display("sent %0d twists, checked %0d results", n_sent, n_checked);
        $display("directed corners, output hold-off, %0d random settings", RANDOM_SETS);
        if (n_errors == 0) begin
            $display("tb_twist_rotate_scale_dominant_axis_top: clean");
        end else begin
            $display("tb_twist_rotate_scale_dominant_axis_top: errors");
        end
        $finish;
    end

endmodule
